>>> rtl/ncbf_pkg.sv
// shared constants, types and helpers of the neighbour compare bit feature unit
// no dependencies
`timescale 1ns / 1ps

package ncbf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;    // width of the geometry registers
  localparam int SEL_W = 3;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int W_EW  = COL_W + 1;   // holds the frame width itself
  localparam int H_EW  = ROW_W + 1;
  localparam int OUT_ROW_W = 11;
  localparam int OUT_COL_W = 11;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [SEL_W-1:0] RST_NB_SELECT    = 3'd0;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH      = 2'd0,
    REG_FRAME_HEIGHT     = 2'd1,
    REG_NEIGHBOUR_SELECT = 2'd2
  } cfg_reg_t;

  // item in the cycle after its line store read
  typedef struct packed {
    logic                 valid;
    logic                 emit;
    logic                 last;
    logic [ROW_W-1:0]     row_m1;
    logic [COL_W-1:0]     col_m1;
    logic [COL_W-1:0]     addr;
    logic [PIX_W-1:0]     px;
  } s1_t;

  typedef struct packed {
    logic                 last;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 bit_val;
  } res_t;

  // window slot of a neighbour, slots in raster order with the centre at 4
  function automatic logic [3:0] win_index(input logic [SEL_W-1:0] sel);
    logic [3:0] idx;
    idx = {1'b0, sel};
    if (sel >= 3'd4) begin
      idx = {1'b0, sel} + 4'd1;
    end
    return idx;
  endfunction

endpackage

>>> rtl/ncbf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ncbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ncbf_pos.sv
// raster position counters, line store read address and stage one register
// depends on ncbf_pkg
`timescale 1ns / 1ps

module ncbf_pos (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [ncbf_pkg::PIX_W-1:0] px,
  input  logic [ncbf_pkg::CFG_W-1:0] cfg_width,
  input  logic [ncbf_pkg::CFG_W-1:0] cfg_height,
  output logic [ncbf_pkg::COL_W-1:0] rd_addr,
  output ncbf_pkg::s1_t              s1
);

  logic [ncbf_pkg::W_EW-1:0]  w_eff;
  logic [ncbf_pkg::H_EW-1:0]  h_eff;
  logic [ncbf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [ncbf_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [ncbf_pkg::W_EW-1:0]  c_ext, c_inc;
  logic [ncbf_pkg::H_EW-1:0]  r_ext, r_inc;
  logic [ncbf_pkg::COL_W-1:0] c;
  logic [ncbf_pkg::ROW_W-1:0] r;
  ncbf_pkg::s1_t              s1_r, s1_nxt;

  // saturate geometry to the supported range
  always_comb begin
    if (32'(cfg_width) > ncbf_pkg::MAX_WIDTH) begin
      w_eff = ncbf_pkg::W_EW'(ncbf_pkg::MAX_WIDTH);
    end else if (cfg_width < 12'd3) begin
      w_eff = ncbf_pkg::W_EW'(3);
    end else begin
      w_eff = ncbf_pkg::W_EW'(cfg_width);
    end
    if (32'(cfg_height) > ncbf_pkg::MAX_HEIGHT) begin
      h_eff = ncbf_pkg::H_EW'(ncbf_pkg::MAX_HEIGHT);
    end else if (cfg_height < 12'd3) begin
      h_eff = ncbf_pkg::H_EW'(3);
    end else begin
      h_eff = ncbf_pkg::H_EW'(cfg_height);
    end
  end

  always_comb begin
    // fold a position left beyond a shrunk geometry
    c_ext = {1'b0, col_r};
    r_ext = {1'b0, row_r};
    if (c_ext >= w_eff) begin
      c_ext = '0;
      r_ext = {1'b0, row_r} + 1'b1;
    end
    if (r_ext >= h_eff) begin
      r_ext = '0;
    end
    c = c_ext[ncbf_pkg::COL_W-1:0];
    r = r_ext[ncbf_pkg::ROW_W-1:0];

    c_inc = {1'b0, c} + 1'b1;
    r_inc = {1'b0, r} + 1'b1;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[ncbf_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c_inc[ncbf_pkg::COL_W-1:0];
      row_nxt = r;
    end

    s1_nxt.valid  = accept;
    s1_nxt.emit   = (r >= ncbf_pkg::ROW_W'(2)) && (c >= ncbf_pkg::COL_W'(2));
    s1_nxt.last   = ({1'b0, r} == h_eff - 1'b1) && ({1'b0, c} == w_eff - 1'b1);
    s1_nxt.row_m1 = r - 1'b1;
    s1_nxt.col_m1 = c - 1'b1;
    s1_nxt.addr   = c;
    s1_nxt.px     = px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= accept;
    end
    if (accept) begin
      s1_r.emit   <= s1_nxt.emit;
      s1_r.last   <= s1_nxt.last;
      s1_r.row_m1 <= s1_nxt.row_m1;
      s1_r.col_m1 <= s1_nxt.col_m1;
      s1_r.addr   <= s1_nxt.addr;
      s1_r.px     <= s1_nxt.px;
    end
  end

  assign rd_addr = c;
  assign s1      = s1_r;

endmodule

>>> rtl/ncbf_window.sv
// 3x3 pixel window and neighbour compare
// depends on ncbf_pkg
`timescale 1ns / 1ps

module ncbf_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  logic [ncbf_pkg::PIX_W-1:0] up,
  input  logic [ncbf_pkg::PIX_W-1:0] lo,
  input  logic [ncbf_pkg::PIX_W-1:0] px,
  input  logic [ncbf_pkg::SEL_W-1:0] sel,
  output logic                       feature_bit
);

  logic [ncbf_pkg::PIX_W-1:0] win_r   [9];
  logic [ncbf_pkg::PIX_W-1:0] win_nxt [9];

  // rows oldest first, newest column on the right
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = lo;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  assign feature_bit = win_nxt[ncbf_pkg::win_index(sel)] < win_nxt[4];

endmodule

>>> rtl/ncbf_out_fifo.sv
// two entry result queue in front of the output channel
// depends on ncbf_pkg
`timescale 1ns / 1ps

module ncbf_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ncbf_pkg::res_t push_data,
  input  logic           pop,
  output logic           valid,
  output ncbf_pkg::res_t data,
  output logic [1:0]     count
);

  ncbf_pkg::res_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_pop;

  assign do_pop = pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  assign valid = (cnt_r != 2'd0);
  assign data  = ent_r[rp_r];
  assign count = cnt_r;

endmodule

>>> rtl/neighbour_compare_bit_feature_unit.sv
// neighbour compare bit feature unit: one channel of a 3x3 census transform
// depends on ncbf_pkg, ncbf_ram, ncbf_pos, ncbf_window, ncbf_out_fifo
`timescale 1ns / 1ps

// a result is offered once the beat of pixel (r,c) that completes the window
//   of its centre (r-1,c-1) has passed the stage one register and the result queue
// throughput: one pixel per cycle while the result queue has room, set by
//   the single read and single write port of each line store ram
// reset: synchronous active low, clears counters, window, queue and
//   registers; line stores are not cleared, no pass needed after reset

module neighbour_compare_bit_feature_unit (
  input  logic        clk,
  input  logic        rst_n,
  // pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [0] feature_bit, [11:1] out_row, [22:12] out_col
  output logic        out_tlast,   // frame_last
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  logic [ncbf_pkg::CFG_W-1:0] frame_width_r;
  logic [ncbf_pkg::CFG_W-1:0] frame_height_r;
  logic [ncbf_pkg::SEL_W-1:0] nb_select_r;

  logic                       in_acc;
  logic                       out_pop;
  logic [ncbf_pkg::COL_W-1:0] rd_addr;
  ncbf_pkg::s1_t              s1;
  logic [ncbf_pkg::PIX_W-1:0] up_rd, lo_rd;
  logic                       feature_bit;
  ncbf_pkg::res_t             res_in, res_out;
  logic                       res_push;
  logic [1:0]                 fifo_cnt;
  logic [2:0]                 occ;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ncbf_pkg::RST_FRAME_WIDTH;
      frame_height_r <= ncbf_pkg::RST_FRAME_HEIGHT;
      nb_select_r    <= ncbf_pkg::RST_NB_SELECT;
    end else if (cfg_we) begin
      case (cfg_index)
        ncbf_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata;
        end
        ncbf_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata;
        end
        ncbf_pkg::REG_NEIGHBOUR_SELECT: begin
          nb_select_r <= cfg_wdata[ncbf_pkg::SEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // every beat in flight may need a queue slot; a slot freed this cycle counts
  assign out_pop = out_tvalid && out_tready;
  assign occ     = {1'b0, fifo_cnt} + {2'b0, s1.valid};
  assign in_tready = (occ < (out_pop ? 3'd3 : 3'd2));
  assign in_acc  = in_tvalid && in_tready;

  ncbf_pos u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .px         (in_tdata),
    .cfg_width  (frame_width_r),
    .cfg_height (frame_height_r),
    .rd_addr    (rd_addr),
    .s1         (s1)
  );

  // line stores: read at the beat's column, written back in the cycle after;
  // the next beat always reads another column, so no forwarding is needed
  ncbf_ram #(
    .WIDTH (ncbf_pkg::PIX_W),
    .DEPTH (ncbf_pkg::MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (s1.valid),
    .waddr (s1.addr),
    .wdata (lo_rd),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  ncbf_ram #(
    .WIDTH (ncbf_pkg::PIX_W),
    .DEPTH (ncbf_pkg::MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (s1.valid),
    .waddr (s1.addr),
    .wdata (s1.px),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (lo_rd)
  );

  ncbf_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift       (s1.valid),
    .up          (up_rd),
    .lo          (lo_rd),
    .px          (s1.px),
    .sel         (nb_select_r),
    .feature_bit (feature_bit)
  );

  // interior centres only
  assign res_push       = s1.valid && s1.emit;
  assign res_in.bit_val = feature_bit;
  assign res_in.row     = ncbf_pkg::OUT_ROW_W'(s1.row_m1);
  assign res_in.col     = ncbf_pkg::OUT_COL_W'(s1.col_m1);
  assign res_in.last    = s1.last;

  ncbf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .data      (res_out),
    .count     (fifo_cnt)
  );

  assign out_tdata = {1'b0, res_out.col, res_out.row, res_out.bit_val};
  assign out_tlast = res_out.last;

`ifndef NO_ASSERTIONS
  // a result never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !(fifo_cnt == 2'd2 && !out_pop))
    else $error("result queue overflow");

  // read data of an accepted beat is consumed in the very next cycle
  a_stage_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1.valid)
    else $error("stage one lost a beat");

  // write back never hits the column being read
  a_addr_split: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1.valid) |-> (rd_addr != s1.addr))
    else $error("line store read and write collide");

  // the queue count never exceeds the queue depth of two
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt != 2'd3)
    else $error("result queue count out of range");
`endif

endmodule

>>> tb/sv/ncbf_feature_checker.sv
// checker for the neighbour compare bit feature unit: predicts every feature bit
// from the pixel and configuration beats it sees, compares result beats in order
// depends on ncbf_pkg
`timescale 1ns / 1ps

module ncbf_feature_checker
  import ncbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          fail_cnt,
  output int          pending_cnt,
  output int          checked_cnt
);

  localparam int MAX_REPORTS = 10;

  // neighbour offsets in raster order, centre skipped
  localparam int NB_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
  localparam int NB_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

  typedef struct packed {
    logic                 hit;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } feature_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [SEL_W-1:0] nb_sel;

  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] lower_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;

  feature_t feature_q [$];

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    checked_cnt = 0;
  end

  function automatic int unsigned size_of(input logic [CFG_W-1:0] raw, input int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic shift_in_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r;
    int          slot;
    logic [PIX_W-1:0] up, lo;
    feature_t    f;
    w = size_of(width_reg, MAX_WIDTH);
    h = size_of(height_reg, MAX_HEIGHT);
    // fold a position left beyond a shrunken geometry
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    up = upper_line[c];
    lo = lower_line[c];
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = px;
    upper_line[c] = lo;
    lower_line[c] = px;
    if (r >= 2 && c >= 2) begin
      slot   = (1 + NB_DY[nb_sel]) * 3 + (1 + NB_DX[nb_sel]);
      f.hit  = (win[slot] < win[4]);
      f.row  = OUT_ROW_W'(r - 1);
      f.col  = OUT_COL_W'(c - 1);
      f.last = (r == h - 1) && (c == w - 1);
      feature_q.push_back(f);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_beat();
    feature_t want, got;
    got.hit  = out_tdata[0];
    got.row  = out_tdata[11:1];
    got.col  = out_tdata[22:12];
    got.last = out_tlast;
    if (feature_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: unexpected result beat bit=%0d row=%0d col=%0d last=%0d",
                 $realtime, got.hit, got.row, got.col, got.last);
    end else begin
      want = feature_q.pop_front();
      checked_cnt++;
      if (got.hit !== want.hit || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: mismatch expected bit=%0d row=%0d col=%0d last=%0d, got bit=%0d row=%0d col=%0d last=%0d",
                   $realtime, want.hit, want.row, want.col, want.last,
                   got.hit, got.row, got.col, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      nb_sel     = RST_NB_SELECT;
      col_pos    = 0;
      row_pos    = 0;
      for (int k = 0; k < 9; k++) win[k] = '0;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        upper_line[k] = '0;
        lower_line[k] = '0;
      end
      feature_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      width_reg  = cfg_wdata;
          REG_FRAME_HEIGHT:     height_reg = cfg_wdata;
          REG_NEIGHBOUR_SELECT: nb_sel     = cfg_wdata[SEL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) shift_in_pixel(in_tdata);
      if (out_tvalid && out_tready) check_beat();
    end
    pending_cnt = feature_q.size();
  end

endmodule

>>> tb/sv/neighbour_compare_bit_feature_unit_tb.sv
// top of the testbench for the neighbour compare bit feature unit: clock, reset,
// pixel and configuration stimulus, output back-pressure, watchdog and verdict
// depends on ncbf_pkg, ncbf_feature_checker and the unit under test
`timescale 1ns / 1ps

module neighbour_compare_bit_feature_unit_tb;
  import ncbf_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 700;   // long output hold-off, fills the result queue
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 400;

  // index past the register list, writes to it must be ignored
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // directed pixels for a 3 wide frame: extremes, equal neighbours, one-off steps
  localparam logic [7:0] DIRECTED_PIX [30] = '{
    8'd0,   8'd255, 8'd128,  8'd128, 8'd128, 8'd0,    8'd255, 8'd1,   8'd254,
    8'd7,   8'd7,   8'd7,    8'd200, 8'd100, 8'd50,   8'd0,   8'd0,   8'd255,
    8'd60,  8'd61,  8'd59,   8'd255, 8'd255, 8'd255,  8'd1,   8'd0,   8'd2,
    8'd90,  8'd170, 8'd85
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [0] feature_bit, [11:1] out_row, [22:12] out_col
  logic        out_tlast;          // frame_last
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_FRAME_WIDTH;
  logic [11:0] cfg_wdata  = '0;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;

  // sender side bookkeeping: beats sent, burst state, raster position
  int unsigned pix_sent   = 0;
  int unsigned frames_done = 0;
  int unsigned burst_left = 0;
  int unsigned pos_col    = 0;
  int unsigned pos_row    = 0;
  int unsigned eff_w      = RST_FRAME_WIDTH;
  int unsigned eff_h      = RST_FRAME_HEIGHT;

  // receiver side: stall pattern and the long hold-off request
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_mode    = 0;
  int unsigned quiet      = 0;

  always #5 clk = ~clk;

  neighbour_compare_bit_feature_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ncbf_feature_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  // receiver: phases of always ready, coin toss and mostly stalled, plus one
  // long hold-off counted here while the sender keeps going
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog: any beat on either stream counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet, pending_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // effective frame size as the unit saturates it
  function automatic int unsigned size_of(input logic [11:0] raw, input int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic logic [7:0] rand_pixel(input bit narrow);
    // narrow range gives lots of equal neighbours
    return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  // register write, one cycle of write enable
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  eff_w = size_of(val, MAX_WIDTH);
      REG_FRAME_HEIGHT: eff_h = size_of(val, MAX_HEIGHT);
      default: ;
    endcase
  endtask

  // stop offering, wait for every expected result, then let border pixels drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one pixel beat, with bursts and gaps on the sender side
  task automatic send_pixel(input logic [7:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pix_sent++;
    // raster position, folded the way the unit folds it
    if (pos_col >= eff_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= eff_h) pos_row = 0;
    pos_col++;
    if (pos_col >= eff_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= eff_h) begin
        pos_row = 0;
        frames_done++;
      end
    end
  endtask

  // one frame from its first pixel, optionally with a geometry or selector
  // change part way through; widths only shrink mid-frame so that no line
  // store entry is read before it was written
  task automatic run_frame(input logic [11:0] w_raw, input logic [11:0] h_raw, input bit midway);
    int unsigned total, k;
    bit          narrow;
    int unsigned pick;
    settle();
    write_reg(REG_FRAME_WIDTH, w_raw);
    write_reg(REG_FRAME_HEIGHT, h_raw);
    write_reg(REG_NEIGHBOUR_SELECT, 12'($urandom_range(0, 7)));
    narrow = ($urandom_range(0, 3) == 0);
    if (midway) begin
      total = eff_w * eff_h;
      k = $urandom_range(1, total - 1);
      repeat (k) send_pixel(rand_pixel(narrow));
      settle();
      pick = $urandom_range(0, 2);
      case (pick)
        0:       write_reg(REG_NEIGHBOUR_SELECT, 12'($urandom_range(0, 7)));
        1:       write_reg(REG_FRAME_WIDTH, 12'($urandom_range(3, eff_w)));
        default: write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(0, 12)));
      endcase
    end
    do send_pixel(rand_pixel(narrow)); while (pos_col != 0 || pos_row != 0);
  endtask

  initial begin
    logic [11:0] w_raw, h_raw;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: width below range saturates to 3, unmapped index must not stick,
    // then a 3 wide frame with the selector stepped through all eight
    // neighbours, one per row, each change landing mid-frame
    write_reg(REG_FRAME_WIDTH, 12'h000);
    write_reg(REG_FRAME_HEIGHT, 12'd10);
    write_reg(REG_NEIGHBOUR_SELECT, 12'd0);
    write_reg(REG_UNMAPPED, 12'hFFF);
    for (int r = 0; r < 10; r++) begin
      if (r >= 2) begin
        settle();
        write_reg(REG_NEIGHBOUR_SELECT, 12'(r - 2));
      end
      for (int c = 0; c < 3; c++) send_pixel(DIRECTED_PIX[r*3 + c]);
    end

    // back-pressure: output held off while pixels keep coming with no gaps
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd16);
    write_reg(REG_FRAME_HEIGHT, 12'd8);
    write_reg(REG_NEIGHBOUR_SELECT, 12'd5);
    hold_req   = 1'b1;
    burst_left = 2000;
    repeat (16 * 8) send_pixel(rand_pixel(1'b0));
    burst_left = 0;

    // tall frame: height above range saturates, then shrinks part way down
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    repeat (24) send_pixel(rand_pixel(1'b0));
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd10);
    do send_pixel(rand_pixel(1'b0)); while (pos_col != 0 || pos_row != 0);

    // random small frames, some with sizes below range
    while (pix_sent < ITEM_TARGET) begin
      w_raw = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 16));
      h_raw = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 10));
      run_frame(w_raw, h_raw, $urandom_range(0, 2) == 0);
    end

    settle();
    $display("run: %0d pixel beats over %0d completed frames, %0d feature bits compared",
             pix_sent, frames_done, checked_cnt);
    $display("run: frames from 3x3 up to 16 wide, saturated sizes, all neighbours, mid-frame changes, %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("mismatches: %0d", fail_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> neighbour_compare_bit_feature_unit.f
rtl/ncbf_pkg.sv
rtl/ncbf_ram.sv
rtl/ncbf_pos.sv
rtl/ncbf_window.sv
rtl/ncbf_out_fifo.sv
rtl/neighbour_compare_bit_feature_unit.sv
tb/sv/ncbf_feature_checker.sv
tb/sv/neighbour_compare_bit_feature_unit_tb.sv
